// File: design/pss_pkg.sv
`timescale 1ns / 1ps

package pss_pkg;

	// Field widths of one beat
	localparam int unsigned FUNC_W   = 1;
	localparam int unsigned PERIOD_W = 16;
	localparam int unsigned FIRE_W   = 10;
	localparam int unsigned COUNT_W  = 32;
	localparam int unsigned INDEX_W  = 4;
	localparam int unsigned STATUS_W = 2;

	// Count bits consumed by the modulo lanes per cycle
	localparam int unsigned DIGIT_W  = 2;
	localparam int unsigned STEPS    = COUNT_W / DIGIT_W;
	localparam int unsigned STEP_W   = $clog2(STEPS);

	// Operation codes
	localparam logic [FUNC_W-1:0] FUNC_TICK = 1'b0;
	localparam logic [FUNC_W-1:0] FUNC_ADD  = 1'b1;

	// Status codes
	localparam logic [STATUS_W-1:0] STAT_OK   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_ZERO = 2'd2;

	typedef struct packed {
		logic [FUNC_W-1:0]   func;
		logic [PERIOD_W-1:0] period;
	} req_t;

	typedef struct packed {
		logic [FIRE_W-1:0]   fire_mask;
		logic [COUNT_W-1:0]  tick_count;
		logic [INDEX_W-1:0]  slot_index;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// Shared control for all modulo lanes
	typedef struct packed {
		logic               clear;
		logic               step;
		logic [DIGIT_W-1:0] bits;
	} lane_ctl_t;

endpackage

// File: design/pss_req_if.sv
`timescale 1ns / 1ps

interface pss_req_if;
	logic          valid;
	logic          ready;
	pss_pkg::req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/pss_rsp_if.sv
`timescale 1ns / 1ps

interface pss_rsp_if;
	logic          valid;
	logic          ready;
	pss_pkg::rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: design/periodic_slot_scheduler.sv
`timescale 1ns / 1ps

// Periodic slot scheduler. An add beat claims the lowest free slot and
// answers once the done state hands it to the output register. A tick beat
// is taken and advances the count; then, in the calc state, every slot
// lane reduces the new count modulo its period two count bits per cycle (a
// restoring compare and subtract per bit); the done state forms the fire mask.
// One beat is worked on at a time; a finished result sits in the output
// register while the next beat is taken. Slots are never freed, and a zero
// period is rejected before the table-full check.
module periodic_slot_scheduler #(
	parameter int unsigned SLOT_COUNT = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	pss_req_if.sink     req,
	pss_rsp_if.source   rsp
);

	localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int unsigned PAD_W  =
		(SLOT_COUNT > pss_pkg::FIRE_W) ? SLOT_COUNT : pss_pkg::FIRE_W;
	localparam int unsigned CNT_W  = pss_pkg::COUNT_W;
	localparam int unsigned DIG_W  = pss_pkg::DIGIT_W;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_CALC = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]                     state_q;
	logic [pss_pkg::STEP_W-1:0]     step_q;
	logic [CNT_W-1:0]               count_q;
	logic [CNT_W-1:0]               count_inc;
	logic [CNT_W-1:0]               shift_q;
	logic [SLOT_COUNT-1:0]          used_q;
	logic [SLOT_COUNT-1:0]          zero;
	logic [SLOT_COUNT-1:0]          wr_en;
	logic                           res_tick_q;
	logic [pss_pkg::INDEX_W-1:0]    res_index_q;
	logic [pss_pkg::STATUS_W-1:0]   res_status_q;
	logic                           rsp_valid_q;
	pss_pkg::rsp_t                  rsp_data_q;
	pss_pkg::lane_ctl_t             lane_ctl;
	logic                           take;
	logic                           take_add;
	logic                           add_ok;
	logic                           free_any;
	logic [SLOT_W-1:0]              free_idx;
	logic                           out_free;
	logic [PAD_W-1:0]               hit_pad;

	assign req.ready = (state_q == ST_IDLE);
	assign take      = req.valid && req.ready;
	assign take_add  = take && (req.data.func == pss_pkg::FUNC_ADD);
	assign add_ok    = take_add && (req.data.period != '0) && free_any;
	assign count_inc = count_q + CNT_W'(1);
	assign out_free  = !rsp_valid_q || rsp.ready;

	// Find the lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
			if (!used_q[i]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(i);
			end
		end
	end

	// Drive shared lane control
	always_comb begin
		lane_ctl.clear = take && (req.data.func == pss_pkg::FUNC_TICK);
		lane_ctl.step  = (state_q == ST_CALC);
		lane_ctl.bits  = shift_q[CNT_W-1 -: DIG_W];
	end

	genvar g;
	generate
		for (g = 0; g < SLOT_COUNT; g++) begin : g_lane
			assign wr_en[g] = add_ok && (free_idx == SLOT_W'(g));

			pss_lane u_lane (
				.clk       (clk),
				.ctl       (lane_ctl),
				.wr_en     (wr_en[g]),
				.wr_period (req.data.period),
				.zero      (zero[g])
			);
		end
	endgenerate

	// Mark claimed slots
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else begin
			used_q <= used_q | wr_en;
		end
	end

	// Sequence one beat: take, reduce (ticks only), hand to the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (take) begin
						step_q <= '0;
						if (req.data.func == pss_pkg::FUNC_TICK) begin
							count_q <= count_inc;
							state_q <= ST_CALC;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_CALC: begin
					step_q <= step_q + pss_pkg::STEP_W'(1);
					if (step_q == pss_pkg::STEP_W'(pss_pkg::STEPS - 1)) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Load the count and shift it out a digit per cycle
	always_ff @(posedge clk) begin
		if (take) begin
			shift_q <= count_inc;
		end else if (state_q == ST_CALC) begin
			shift_q <= shift_q << DIG_W;
		end
	end

	// Hold the pending result of the beat in flight
	always_ff @(posedge clk) begin
		if (take) begin
			res_tick_q <= (req.data.func == pss_pkg::FUNC_TICK);
			if (req.data.func == pss_pkg::FUNC_TICK) begin
				res_index_q  <= '0;
				res_status_q <= pss_pkg::STAT_OK;
			end else if (req.data.period == '0) begin
				res_index_q  <= '0;
				res_status_q <= pss_pkg::STAT_ZERO;
			end else if (!free_any) begin
				res_index_q  <= '0;
				res_status_q <= pss_pkg::STAT_FULL;
			end else begin
				res_index_q  <= pss_pkg::INDEX_W'(free_idx);
				res_status_q <= pss_pkg::STAT_OK;
			end
		end
	end

	// Fire every claimed slot whose remainder is zero
	assign hit_pad = PAD_W'(used_q & zero);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == ST_DONE && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && out_free) begin
			rsp_data_q.fire_mask  <= res_tick_q ? hit_pad[pss_pkg::FIRE_W-1:0] : '0;
			rsp_data_q.tick_count <= count_q;
			rsp_data_q.slot_index <= res_index_q;
			rsp_data_q.status     <= res_status_q;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.data  = rsp_data_q;

endmodule

// File: design/pss_lane.sv
`timescale 1ns / 1ps

// One slot: holds its period and reduces the tick count modulo that period,
// most significant digit first, with a restoring compare and subtract.
module pss_lane (
	input  logic                             clk,
	input  pss_pkg::lane_ctl_t               ctl,
	input  logic                             wr_en,
	input  logic [pss_pkg::PERIOD_W-1:0]     wr_period,
	output logic                             zero
);

	localparam int unsigned PER_W = pss_pkg::PERIOD_W;

	logic [PER_W-1:0] period_q;
	logic [PER_W-1:0] rem_q;
	logic [PER_W-1:0] rem_next;
	logic [PER_W:0]   shifted;

	// Store period on a claiming add
	always_ff @(posedge clk) begin
		if (wr_en) begin
			period_q <= wr_period;
		end
	end

	// Shift in one digit and reduce below the period
	always_comb begin
		rem_next = rem_q;
		shifted  = '0;
		for (int k = pss_pkg::DIGIT_W - 1; k >= 0; k--) begin
			shifted = {rem_next, ctl.bits[k]};
			if (shifted >= {1'b0, period_q}) begin
				rem_next = PER_W'(shifted - {1'b0, period_q});
			end else begin
				rem_next = shifted[PER_W-1:0];
			end
		end
	end

	// Advance remainder
	always_ff @(posedge clk) begin
		if (ctl.clear) begin
			rem_q <= '0;
		end else if (ctl.step) begin
			rem_q <= rem_next;
		end
	end

	assign zero = (rem_q == '0);

endmodule

// File: verif/tb_periodic_slot_scheduler.sv
`timescale 1ns / 1ps

module tb_periodic_slot_scheduler;

	import pss_pkg::*;

	localparam int unsigned SLOTS       = 10;
	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned DRAIN_WAIT  = 40;
	localparam int unsigned RAND_ITEMS  = 400;

	// Tracks the slot table and tick count, and holds the results still owed
	class slot_schedule_model;
		logic [COUNT_W-1:0]  ticks;
		logic [PERIOD_W-1:0] periods [SLOTS];
		bit                  taken [SLOTS];
		rsp_t                pending_results [$];
		int                  errors;

		function new();
			ticks  = '0;
			errors = 0;
			for (int i = 0; i < SLOTS; i++) begin
				periods[i] = '0;
				taken[i]   = 1'b0;
			end
		endfunction

		// Work out the result of one accepted request beat
		function void predict_req(req_t r);
			rsp_t e;
			bit   found;
			e     = '0;
			found = 1'b0;
			if (r.func == FUNC_TICK) begin
				ticks = ticks + 1'b1;
				for (int i = 0; i < SLOTS; i++) begin
					if (taken[i] && periods[i] != '0 && i < FIRE_W &&
					    (ticks % {16'd0, periods[i]}) == '0)
						e.fire_mask[i] = 1'b1;
				end
			end else if (r.period == '0) begin
				e.status = STAT_ZERO;
			end else begin
				// Claim the lowest free slot, or report a full table
				e.status = STAT_FULL;
				for (int i = 0; i < SLOTS; i++) begin
					if (!found && !taken[i]) begin
						found        = 1'b1;
						taken[i]     = 1'b1;
						periods[i]   = r.period;
						e.slot_index = INDEX_W'(i);
						e.status     = STAT_OK;
					end
				end
			end
			e.tick_count = ticks;
			pending_results.push_back(e);
		endfunction

		// Compare one accepted response beat with the oldest expectation
		function void check_rsp(rsp_t got);
			rsp_t e;
			if (pending_results.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, got);
				errors++;
				return;
			end
			e = pending_results.pop_front();
			if (got.fire_mask !== e.fire_mask) begin
				$display("%0t fire_mask: expected %h, actual %h",
				         $time, e.fire_mask, got.fire_mask);
				errors++;
			end
			if (got.tick_count !== e.tick_count) begin
				$display("%0t tick_count: expected %h, actual %h",
				         $time, e.tick_count, got.tick_count);
				errors++;
			end
			if (got.slot_index !== e.slot_index) begin
				$display("%0t slot_index: expected %h, actual %h",
				         $time, e.slot_index, got.slot_index);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t status: expected %h, actual %h",
				         $time, e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	bit   calm = 1'b0;
	int   cycles = 0;

	slot_schedule_model sched = new();

	pss_req_if req_if ();
	pss_rsp_if rsp_if ();

	periodic_slot_scheduler #(
		.SLOT_COUNT(SLOTS)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #4 clk = ~clk;

	// Give up on a hung run
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("tb_periodic_slot_scheduler: errors");
			$finish;
		end
	end

	// Take response beats and stall the result side at random
	always @(posedge clk) begin
		if (rsp_if.valid && rsp_if.ready)
			sched.check_rsp(rsp_if.data);
		rsp_if.ready <= calm || ($urandom_range(99) >= 26);
	end

	// Present one request beat, maybe after a gap, and hold it until taken
	task automatic send_req(input logic [FUNC_W-1:0] f, input logic [PERIOD_W-1:0] p);
		req_t r;
		int   gap;
		r.func   = f;
		r.period = p;
		if (!calm && $urandom_range(99) < 26) begin
			req_if.valid <= 1'b0;
			gap = $urandom_range(1, 4);
			repeat (gap) @(posedge clk);
		end
		req_if.valid <= 1'b1;
		req_if.data  <= r;
		do @(posedge clk); while (!(req_if.valid && req_if.ready));
		sched.predict_req(r);
	endtask

	task automatic send_ticks(input int n);
		for (int i = 0; i < n; i++)
			send_req(FUNC_TICK, PERIOD_W'($urandom_range(0, 65535)));
	endtask

	initial begin
		int adds_ok;
		int pick;
		logic [PERIOD_W-1:0] p;

		req_if.valid = 1'b0;
		req_if.data  = '0;
		rsp_if.ready = 1'b0;
		arst_n       = 1'b0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: empty table, zero period, lowest-slot claims, field extremes
		send_ticks(2);
		send_req(FUNC_ADD, 16'd0);
		send_req(FUNC_ADD, 16'd1);
		send_req(FUNC_ADD, 16'd2);
		send_req(FUNC_ADD, 16'd3);
		send_ticks(6);
		send_req(FUNC_ADD, 16'hFFFF);
		send_req(FUNC_ADD, 16'h8000);
		send_req(FUNC_ADD, 16'd0);
		send_req(FUNC_TICK, 16'hFFFF);
		send_ticks(4);
		adds_ok = 5;

		// Random: mostly ticks; fill the table with short periods, then hit it full
		for (int n = 0; n < RAND_ITEMS; n++) begin
			calm = (n >= 150 && n < 250);
			pick = $urandom_range(99);
			if (pick < 70) begin
				send_req(FUNC_TICK, PERIOD_W'($urandom_range(0, 65535)));
			end else if (pick < 76) begin
				send_req(FUNC_ADD, 16'd0);
			end else begin
				if (adds_ok < SLOTS && $urandom_range(3) != 0)
					p = PERIOD_W'($urandom_range(1, 12));
				else
					p = PERIOD_W'($urandom_range(1, 65535));
				send_req(FUNC_ADD, p);
				adds_ok++;
			end
		end
		req_if.valid <= 1'b0;
		calm = 1'b0;

		// Drain the results still owed, then watch for strays
		while (sched.pending_results.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		if (sched.pending_results.size() != 0) begin
			$display("%0t missing results: expected %0d more, actual 0",
			         $time, sched.pending_results.size());
			sched.errors++;
		end
		if (sched.errors == 0)
			$display("tb_periodic_slot_scheduler: clean");
		else
			$display("tb_periodic_slot_scheduler: errors");
		$finish;
	end

endmodule
